>>> rtl/cq_pkg.sv
// shared types and constants for the circular queue fifo
// no dependencies; imported by the controller, datapath and top level
`default_nettype none

package cq_pkg;

    localparam int unsigned CAP_W    = 5;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned STATUS_W = 2;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK    = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } cq_state_t;

    typedef struct packed {
        logic latch_in;
        logic exec;
    } cq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } cq_stat_t;

endpackage

`default_nettype wire

>>> rtl/cq_ctrl.sv
// controller state machine of the circular queue fifo
// depends on cq_pkg; drives the stream handshakes and the datapath commands
`default_nettype none

module cq_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    input  wire cq_pkg::cq_stat_t stat,
    output cq_pkg::cq_cmd_t      cmd
);
    import cq_pkg::*;

    cq_state_t state_reg;
    cq_state_t state_next;
    logic      out_valid_reg;
    logic      out_valid_next;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        cmd.latch_in = s_axis_tvalid && s_axis_tready;
        // the result register must be free, or emptied in this cycle
        cmd.exec     = (state_reg == S_EXEC) && (!out_valid_reg || m_axis_tready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.latch_in)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (cmd.exec)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> m_axis_tvalid)
        else $error("result not presented after execution");

    a_accept_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch_in |=> (state_reg == S_EXEC))
        else $error("accepted transaction not executed");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !cmd.exec)
        else $error("pending result overwritten");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("queue both full and empty");

endmodule

`default_nettype wire

>>> rtl/cq_dpath.sv
// datapath of the circular queue fifo: slot memory, indices, count, result register
// depends on cq_pkg; commanded by cq_ctrl
`default_nettype none

module cq_dpath
#(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cq_pkg::cq_cmd_t               cmd,
    output cq_pkg::cq_stat_t                   stat,
    input  wire logic                          cfg_wr_en,
    input  wire logic [cq_pkg::CAP_W-1:0]      cfg_wr_data,
    input  wire logic [cq_pkg::ACTION_W-1:0]   in_action,
    input  wire logic [DATA_WIDTH-1:0]         in_data,
    output logic [DATA_WIDTH-1:0]              out_head,
    output logic [DATA_WIDTH-1:0]              out_tail,
    output logic [cq_pkg::STATUS_W-1:0]        out_status,
    output logic [cq_pkg::COUNT_W-1:0]         out_count,
    output logic                               out_empty,
    output logic                               out_full
);
    import cq_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CMP_W = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;
    localparam logic [CAP_W-1:0] EFF_RESET =
        (DEPTH < 16) ? CAP_W'(DEPTH) : CAP_RESET;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [PTR_W-1:0]      head_ptr_reg, head_ptr_next;
    logic [PTR_W-1:0]      tail_ptr_reg, tail_ptr_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [CAP_W-1:0]      eff_cap_reg;
    logic [CAP_W-1:0]      cap_clamped;
    logic [DATA_WIDTH-1:0] newest_reg, newest_next;
    logic [ACTION_W-1:0]   action_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic                  mem_we;

    logic [DATA_WIDTH-1:0] res_head, res_tail;
    logic [STATUS_W-1:0]   res_status;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
        logic [CMP_W-1:0] n;
        n = CMP_W'(idx) + CMP_W'(1);
        return (n >= CMP_W'(cap)) ? '0 : PTR_W'(n);
    endfunction

    // zero behaves as one, anything past the built-in depth as the depth
    always_comb
    begin
        cap_clamped = cfg_wr_data;
        if (cfg_wr_data == '0)
            cap_clamped = CAP_W'(1);
        else if (32'(cfg_wr_data) > DEPTH)
            cap_clamped = CAP_W'(DEPTH);
    end

    always_comb
    begin
        head_ptr_next = head_ptr_reg;
        tail_ptr_next = tail_ptr_reg;
        count_next    = count_reg;
        newest_next   = newest_reg;
        mem_we        = 1'b0;
        res_status    = STAT_OK;
        res_head      = (count_reg != '0) ? rd_data_reg : '0;

        case (action_reg)
            ACT_ENQUEUE:
            begin
                if (count_reg >= eff_cap_reg)
                    res_status = STAT_OVERFLOW;
                else
                begin
                    mem_we        = 1'b1;
                    tail_ptr_next = advance(tail_ptr_reg, eff_cap_reg);
                    count_next    = count_reg + COUNT_W'(1);
                    newest_next   = data_reg;
                end
            end
            ACT_DEQUEUE:
            begin
                if (count_reg == '0)
                    res_status = STAT_UNDERFLOW;
                else
                begin
                    head_ptr_next = advance(head_ptr_reg, eff_cap_reg);
                    count_next    = count_reg - COUNT_W'(1);
                end
            end
            default:
            begin
                // peek, and the unused code, leave the queue alone
                if (count_reg == '0)
                    res_status = STAT_UNDERFLOW;
            end
        endcase

        res_tail = (count_next != '0) ? newest_next : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
            mem[tail_ptr_reg] <= data_reg;
        rd_data_reg <= mem[head_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            count_reg    <= '0;
            eff_cap_reg  <= EFF_RESET;
        end
        else if (cfg_wr_en)
        begin
            head_ptr_reg <= '0;
            tail_ptr_reg <= '0;
            count_reg    <= '0;
            eff_cap_reg  <= cap_clamped;
        end
        else if (cmd.exec)
        begin
            head_ptr_reg <= head_ptr_next;
            tail_ptr_reg <= tail_ptr_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            action_reg <= in_action;
            data_reg   <= in_data;
        end
        if (cmd.exec)
        begin
            newest_reg <= newest_next;
            out_head   <= res_head;
            out_tail   <= res_tail;
            out_status <= res_status;
            out_count  <= count_next;
            out_empty  <= (count_next == '0);
            out_full   <= (count_next == eff_cap_reg);
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == eff_cap_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= eff_cap_reg)
        else $error("entry count beyond capacity");

    a_empty_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_ptr_reg == tail_ptr_reg))
        else $error("empty queue with misaligned indices");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CMP_W'(head_ptr_reg) < CMP_W'(eff_cap_reg)) &&
        (CMP_W'(tail_ptr_reg) < CMP_W'(eff_cap_reg)))
        else $error("index beyond wrap point");

endmodule

`default_nettype wire

>>> rtl/circular_queue_fifo.sv
// top level of the circular queue fifo
// depends on cq_pkg, cq_ctrl and cq_dpath
//
// usage:
//   slave stream carries one operation per transaction: tuser selects
//   enqueue, dequeue or peek, tdata holds the word to append.
//   master stream returns one result per operation: head word seen before
//   the operation, newest held word after it, entry count and flags in
//   tdata, the status code in tuser.
//   cfg_wr_en/cfg_wr_data set the usable capacity and empty the queue;
//   write it only while no transaction is in flight.
// timing:
//   an operation is taken in S_IDLE and executed in S_EXEC, when the
//   registered read of the head slot is ready; no new operation is taken
//   until the last has executed, and the result is registered at execution.
//   while a result waits for m_axis_tready, execution of the following
//   operation holds in the controller and s_axis_tready stays low.
// reset:
//   queue empty, capacity sixteen (or the depth if smaller); slot contents
//   are not cleared and are never read before being written.
`default_nettype none

module circular_queue_fifo
#(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [cq_pkg::CAP_W-1:0]           cfg_wr_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // data_in
    input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // action
    input  wire logic [cq_pkg::ACTION_W-1:0]        s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // head_value, tail_value, entry_count, is_empty, is_full
    output logic [((2*DATA_WIDTH+cq_pkg::COUNT_W+2+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [cq_pkg::STATUS_W-1:0]             m_axis_tuser
);
    import cq_pkg::*;

    localparam int unsigned OUT_BITS = 2 * DATA_WIDTH + COUNT_W + 2;
    localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    cq_cmd_t               cmd;
    cq_stat_t              stat;
    logic [DATA_WIDTH-1:0] out_head, out_tail;
    logic [COUNT_W-1:0]    out_count;
    logic                  out_empty, out_full;

    cq_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    cq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_action   (s_axis_tuser),
        .in_data     (s_axis_tdata[DATA_WIDTH-1:0]),
        .out_head    (out_head),
        .out_tail    (out_tail),
        .out_status  (m_axis_tuser),
        .out_count   (out_count),
        .out_empty   (out_empty),
        .out_full    (out_full)
    );

    assign m_axis_tdata = OUT_W'({out_full, out_empty, out_count, out_tail, out_head});

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// self-checking testbench for circular_queue_fifo: directed table, then random phases
// depends on cq_pkg and the circular_queue_fifo rtl; results checked against an internal model
`timescale 1ns / 1ps

module tb_top;

    import cq_pkg::*;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned S_W        = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int unsigned M_W        = ((2 * DATA_WIDTH + COUNT_W + 2 + 7) / 8) * 8;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned N_PHASES   = 12;
    localparam int unsigned PHASE_OPS  = 130;

    // code 3 is unused by the block and behaves as a peek
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] head;
        logic [DATA_WIDTH-1:0] tail;
        logic [STATUS_W-1:0]   status;
        logic [COUNT_W-1:0]    count;
        logic                  empty;
        logic                  full;
    } queue_result_t;

    typedef struct {
        bit                    is_cap;
        logic [CAP_W-1:0]      cap;
        logic [ACTION_W-1:0]   act;
        logic [DATA_WIDTH-1:0] word;
        bit                    typed;
        queue_result_t         res;
    } table_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CAP_W-1:0]      cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_W-1:0]        s_axis_tdata;
    logic [ACTION_W-1:0]   s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_W-1:0]        m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    // model of the queue
    logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
    int unsigned           q_head;
    int unsigned           q_tail;
    int unsigned           q_count;
    logic [CAP_W-1:0]      cap_setting;

    queue_result_t         pending_results [$];
    table_row_t            directed [$];
    int unsigned           error_count;
    int unsigned           burst_left;

    circular_queue_fifo #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned wrap_point();
        if (cap_setting == 0)
            return 1;
        if (cap_setting > DEPTH)
            return DEPTH;
        return cap_setting;
    endfunction

    function automatic int unsigned next_slot(int unsigned idx, int unsigned cap);
        return (idx + 1 >= cap) ? 0 : idx + 1;
    endfunction

    // applies one operation to the model and returns what the block should report
    function automatic queue_result_t step_queue(logic [ACTION_W-1:0] act,
                                                 logic [DATA_WIDTH-1:0] word);
        queue_result_t r;
        int unsigned   cap;
        int unsigned   last;
        cap      = wrap_point();
        r        = '0;
        r.status = STAT_OK;
        if (q_count != 0)
            r.head = slot_mem[q_head];
        if (act == ACT_ENQUEUE)
        begin
            if (q_count >= cap)
                r.status = STAT_OVERFLOW;
            else
            begin
                slot_mem[q_tail] = word;
                q_tail  = next_slot(q_tail, cap);
                q_count = q_count + 1;
            end
        end
        else if (act == ACT_DEQUEUE)
        begin
            if (q_count == 0)
                r.status = STAT_UNDERFLOW;
            else
            begin
                q_head  = next_slot(q_head, cap);
                q_count = q_count - 1;
            end
        end
        else if (q_count == 0)
            r.status = STAT_UNDERFLOW;
        if (q_count != 0)
        begin
            last   = (q_tail == 0) ? cap - 1 : q_tail - 1;
            r.tail = slot_mem[last];
        end
        r.count = q_count[COUNT_W-1:0];
        r.empty = (q_count == 0);
        r.full  = (q_count == cap);
        return r;
    endfunction

    function automatic queue_result_t mk_res(logic [DATA_WIDTH-1:0] head,
                                             logic [DATA_WIDTH-1:0] tail,
                                             logic [STATUS_W-1:0] status,
                                             logic [COUNT_W-1:0] count,
                                             logic empty, logic full);
        queue_result_t r;
        r.head   = head;
        r.tail   = tail;
        r.status = status;
        r.count  = count;
        r.empty  = empty;
        r.full   = full;
        return r;
    endfunction

    task automatic add_op(logic [ACTION_W-1:0] act, logic [DATA_WIDTH-1:0] word);
        table_row_t row;
        row        = '{default: '0};
        row.act    = act;
        row.word   = word;
        directed.push_back(row);
    endtask

    task automatic add_chk(logic [ACTION_W-1:0] act, logic [DATA_WIDTH-1:0] word,
                           queue_result_t res);
        table_row_t row;
        row        = '{default: '0};
        row.act    = act;
        row.word   = word;
        row.typed  = 1'b1;
        row.res    = res;
        directed.push_back(row);
    endtask

    task automatic add_cap(logic [CAP_W-1:0] cap);
        table_row_t row;
        row        = '{default: '0};
        row.is_cap = 1'b1;
        row.cap    = cap;
        directed.push_back(row);
    endtask

    // drives one transaction, records its expected result, and handles burst gaps
    task automatic send_op(logic [ACTION_W-1:0] act, logic [DATA_WIDTH-1:0] word,
                           bit typed, queue_result_t typed_res);
        queue_result_t predicted;
        int unsigned   gap;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = step_queue(act, word);
        pending_results.push_back(typed ? typed_res : predicted);
        if (burst_left > 0)
            burst_left = burst_left - 1;
        if (burst_left == 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = $urandom;
            s_axis_tuser  = ACTION_W'($urandom_range(0, 3));
            gap = $urandom_range(0, 6);
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // hold the sender until every outstanding result has been taken
    task automatic drain_queue();
        if (s_axis_tvalid)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain_queue();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = cap;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cfg_wr_data = CAP_W'($urandom);
        cap_setting = cap;
        q_head  = 0;
        q_tail  = 0;
        q_count = 0;
    endtask

    function automatic logic [DATA_WIDTH-1:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // receiver: runs of ready and stall, with long stretches of no back-pressure
    initial
    begin
        int unsigned run_len;
        bit          run_ready;
        run_len       = 0;
        run_ready     = 1'b1;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run_len == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        run_ready = 1'b1;
                        run_len   = $urandom_range(20, 80);
                    end
                    2:
                    begin
                        run_ready = 1'b0;
                        run_len   = $urandom_range(5, 25);
                    end
                    default:
                    begin
                        run_ready = ~run_ready;
                        run_len   = run_ready ? $urandom_range(1, 6) : $urandom_range(1, 3);
                    end
                endcase
            end
            m_axis_tready = run_ready && rst_n;
            run_len = run_len - 1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        queue_result_t want;
        queue_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.head   = m_axis_tdata[DATA_WIDTH-1:0];
            got.tail   = m_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
            got.count  = m_axis_tdata[2*DATA_WIDTH+COUNT_W-1:2*DATA_WIDTH];
            got.empty  = m_axis_tdata[2*DATA_WIDTH+COUNT_W];
            got.full   = m_axis_tdata[2*DATA_WIDTH+COUNT_W+1];
            got.status = m_axis_tuser;
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing outstanding");
                error_count = error_count + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.head !== want.head)
                begin
                    $error("head_value: expected %h, got %h", want.head, got.head);
                    error_count = error_count + 1;
                end
                if (got.tail !== want.tail)
                begin
                    $error("tail_value: expected %h, got %h", want.tail, got.tail);
                    error_count = error_count + 1;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count = error_count + 1;
                end
                if (got.count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, got.count);
                    error_count = error_count + 1;
                end
                if (got.empty !== want.empty)
                begin
                    $error("is_empty: expected %0d, got %0d", want.empty, got.empty);
                    error_count = error_count + 1;
                end
                if (got.full !== want.full)
                begin
                    $error("is_full: expected %0d, got %0d", want.full, got.full);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [CAP_W-1:0]      cap;
        logic [ACTION_W-1:0]   act;
        int unsigned           pick;
        int unsigned           seg_left;
        bit                    filling;
        table_row_t            row;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_PEEK;
        error_count   = 0;
        burst_left    = 1;
        cap_setting   = CAP_RESET;
        q_head        = 0;
        q_tail        = 0;
        q_count       = 0;
        foreach (slot_mem[i])
            slot_mem[i] = '0;

        // after reset: empty queue at capacity sixteen
        add_chk(ACT_PEEK,    32'h1234_5678, mk_res('0, '0, STAT_UNDERFLOW, 5'd0, 1'b1, 1'b0));
        add_chk(ACT_DEQUEUE, 32'h0000_0000, mk_res('0, '0, STAT_UNDERFLOW, 5'd0, 1'b1, 1'b0));
        add_chk(ACT_ENQUEUE, 32'h7FFF_FFFF,
                mk_res('0, 32'h7FFF_FFFF, STAT_OK, 5'd1, 1'b0, 1'b0));
        add_chk(ACT_ENQUEUE, 32'h8000_0000,
                mk_res(32'h7FFF_FFFF, 32'h8000_0000, STAT_OK, 5'd2, 1'b0, 1'b0));
        add_chk(ACT_SPARE,   32'hFFFF_FFFF,
                mk_res(32'h7FFF_FFFF, 32'h8000_0000, STAT_OK, 5'd2, 1'b0, 1'b0));
        add_chk(ACT_DEQUEUE, 32'h0000_0000,
                mk_res(32'h7FFF_FFFF, 32'h8000_0000, STAT_OK, 5'd1, 1'b0, 1'b0));
        add_chk(ACT_DEQUEUE, 32'h0000_0000,
                mk_res(32'h8000_0000, '0, STAT_OK, 5'd0, 1'b1, 1'b0));
        // single entry queue: full after one, overflow on the second
        add_cap(5'd1);
        add_chk(ACT_ENQUEUE, 32'hFFFF_FFFF,
                mk_res('0, 32'hFFFF_FFFF, STAT_OK, 5'd1, 1'b0, 1'b1));
        add_chk(ACT_ENQUEUE, 32'h0000_0000,
                mk_res(32'hFFFF_FFFF, 32'hFFFF_FFFF, STAT_OVERFLOW, 5'd1, 1'b0, 1'b1));
        add_chk(ACT_PEEK,    32'h0000_0000,
                mk_res(32'hFFFF_FFFF, 32'hFFFF_FFFF, STAT_OK, 5'd1, 1'b0, 1'b1));
        add_chk(ACT_DEQUEUE, 32'h0000_0000,
                mk_res(32'hFFFF_FFFF, '0, STAT_OK, 5'd0, 1'b1, 1'b0));
        // zero capacity behaves as one
        add_cap(5'd0);
        add_chk(ACT_ENQUEUE, 32'h0000_0001, mk_res('0, 32'h1, STAT_OK, 5'd1, 1'b0, 1'b1));
        add_chk(ACT_ENQUEUE, 32'h0000_0002,
                mk_res(32'h1, 32'h1, STAT_OVERFLOW, 5'd1, 1'b0, 1'b1));
        // over-range capacity clamps to depth; the write also empties the queue
        add_cap(5'd31);
        add_chk(ACT_PEEK,    32'h0000_0000, mk_res('0, '0, STAT_UNDERFLOW, 5'd0, 1'b1, 1'b0));
        // two entries: index wrap on both ends
        add_cap(5'd2);
        add_op(ACT_ENQUEUE, 32'hA5A5_A5A5);
        add_op(ACT_ENQUEUE, 32'h5A5A_5A5A);
        add_op(ACT_DEQUEUE, 32'h0000_0000);
        add_op(ACT_ENQUEUE, 32'h0000_0001);
        add_op(ACT_ENQUEUE, 32'h0000_0002);
        add_op(ACT_DEQUEUE, 32'h0000_0000);
        add_op(ACT_DEQUEUE, 32'h0000_0000);
        add_op(ACT_DEQUEUE, 32'h0000_0000);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            row = directed[i];
            if (row.is_cap)
                write_capacity(row.cap);
            else
                send_op(row.act, row.word, row.typed, row.res);
        end

        // random phases, each at its own capacity; fill and drain segments
        // push the queue to both full and empty
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0: cap = 5'd16;
                1: cap = 5'd1;
                2: cap = 5'd31;
                3: cap = 5'd0;
                4: cap = 5'd2;
                5: cap = 5'd5;
                6: cap = 5'd16;
                7: cap = CAP_W'($urandom_range(1, 16));
                8: cap = 5'd3;
                9: cap = CAP_W'($urandom_range(0, 31));
                10: cap = 5'd16;
                default: cap = 5'd7;
            endcase
            write_capacity(cap);
            seg_left = 0;
            filling  = 1'b1;
            for (int n = 0; n < PHASE_OPS; n++)
            begin
                if (seg_left == 0)
                begin
                    filling  = ~filling;
                    seg_left = $urandom_range(4, 40);
                end
                seg_left = seg_left - 1;
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    act = ACT_SPARE;
                else if (filling)
                    act = (pick < 75) ? ACT_ENQUEUE : (pick < 88) ? ACT_DEQUEUE : ACT_PEEK;
                else
                    act = (pick < 20) ? ACT_ENQUEUE : (pick < 85) ? ACT_DEQUEUE : ACT_PEEK;
                send_op(act, pick_word(), 1'b0, '0);
                // in every third phase the sender holds off mid-phase until the output side has caught up
                if (n == PHASE_OPS / 2 && p % 3 == 0)
                    drain_queue();
            end
        end

        drain_queue();
        repeat (10) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> circular_queue_fifo.f
rtl/cq_pkg.sv
rtl/cq_ctrl.sv
rtl/cq_dpath.sv
rtl/circular_queue_fifo.sv
verif/tb_top.sv
